FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a implies b in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Check that a implies b in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/rcw_pkg.sv
// Types and constants of the RIFF chunk header walker.
// Depends on nothing.
`default_nettype none
package rcw_pkg;

    localparam logic [1:0] EV_HEADER   = 2'd0;
    localparam logic [1:0] EV_CHUNK    = 2'd1;
    localparam logic [1:0] EV_NOT_RIFF = 2'd2;
    localparam logic [1:0] EV_TRUNC    = 2'd3;

    localparam logic [31:0] RIFF_WORD  = {8'h46, 8'h46, 8'h49, 8'h52};
    localparam logic [31:0] TYPE_BYTES = 32'd4;
    localparam logic [32:0] HDR_BYTES  = 33'd8;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] tag;
        logic [31:0] length;
        logic [31:0] bytes_left;
        logic        walk_done;
    } rcw_result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/riff_chunk_header_walker.sv
// RIFF chunk header walker: one byte word accepted per cycle while in_stall is low.
// Each result is registered in the output buffer on its way to the outputs.
// The input stalls only while the result and skid registers are both full,
// as set by the two-entry output buffer.
// Reset (rst_n low, asynchronous) returns the walk to the magic check and empties the buffer.
// Top level; depends on rcw_pkg, rcw_walker and rcw_out_buf.
`default_nettype none
module riff_chunk_header_walker
    import rcw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_file,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       event_res,
    output logic [31:0]      tag,
    output logic [31:0]      length,
    output logic [31:0]      bytes_left,
    output logic             walk_done
);

    logic        accept;
    logic        res_valid;
    logic        buf_full;
    rcw_result_t res;
    rcw_result_t out_data;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    rcw_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .res_valid   (res_valid),
        .res         (res)
    );

    rcw_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign event_res  = out_data.event_res;
    assign tag        = out_data.tag;
    assign length     = out_data.length;
    assign bytes_left = out_data.bytes_left;
    assign walk_done  = out_data.walk_done;

endmodule
`default_nettype wire

FILE: hw/rtl/rcw_walker.sv
// Walk state and per-word result logic of the RIFF chunk header walker.
// Depends on rcw_pkg.
`default_nettype none
module rcw_walker
    import rcw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_file,
    output logic             res_valid,
    output rcw_result_t      res
);

    localparam logic [2:0] PH_MAGIC  = 3'd0;
    localparam logic [2:0] PH_SIZE   = 3'd1;
    localparam logic [2:0] PH_TYPE   = 3'd2;
    localparam logic [2:0] PH_CHID   = 3'd3;
    localparam logic [2:0] PH_CHSIZE = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    logic [2:0]  phase_reg,  phase_next;
    logic [1:0]  index_reg,  index_next;
    logic [31:0] gather_reg, gather_next;
    logic [31:0] held_reg,   held_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] skip_reg,   skip_next;

    logic        full;
    logic [31:0] w;
    logic [32:0] deduct;
    logic [31:0] chunk_left;
    logic [31:0] type_left;
    logic        go;
    logic        hit;

    always_comb
    begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        gather_next = gather_reg;
        held_next   = held_reg;
        remain_next = remain_reg;
        skip_next   = skip_reg;
        full        = 1'b0;
        hit         = 1'b0;
        res         = '0;
        w           = {data_byte, gather_reg[31:8]};
        deduct      = HDR_BYTES + {1'b0, w};
        chunk_left  = ({1'b0, remain_reg} > deduct) ? (remain_reg - deduct[31:0]) : '0;
        type_left   = (remain_reg > TYPE_BYTES) ? (remain_reg - TYPE_BYTES) : '0;
        go          = (chunk_left != '0) && (w != '0) && !w[31];

        if (phase_reg != PH_SKIP && phase_reg != PH_DONE)
        begin
            gather_next = w;
            full        = (index_reg == 2'd3);
            index_next  = index_reg + 2'd1;
        end

        case (phase_reg)
            PH_MAGIC:
            begin
                if (full)
                begin
                    if (w == RIFF_WORD)
                    begin
                        phase_next = PH_SIZE;
                    end
                    else
                    begin
                        hit            = 1'b1;
                        res.event_res  = EV_NOT_RIFF;
                        res.tag        = w;
                        res.walk_done  = 1'b1;
                        phase_next     = PH_DONE;
                    end
                end
            end
            PH_SIZE:
            begin
                if (full)
                begin
                    remain_next = w;
                    phase_next  = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                if (full)
                begin
                    hit            = 1'b1;
                    res.event_res  = EV_HEADER;
                    res.tag        = w;
                    res.length     = remain_reg;
                    res.bytes_left = type_left;
                    remain_next    = type_left;
                    phase_next     = PH_CHID;
                end
            end
            PH_CHID:
            begin
                if (full)
                begin
                    held_next  = w;
                    phase_next = PH_CHSIZE;
                end
            end
            PH_CHSIZE:
            begin
                if (full)
                begin
                    hit            = 1'b1;
                    res.event_res  = EV_CHUNK;
                    res.tag        = held_reg;
                    res.length     = w;
                    res.bytes_left = chunk_left;
                    res.walk_done  = !go;
                    remain_next    = chunk_left;
                    if (go)
                    begin
                        skip_next  = w;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 32'd1;
                if (skip_next == '0)
                begin
                    index_next = '0;
                    phase_next = PH_CHID;
                end
            end
            default:
            begin
            end
        endcase

        if (end_of_file)
        begin
            if (phase_next != PH_DONE)
            begin
                hit            = 1'b1;
                res            = '0;
                res.event_res  = EV_TRUNC;
                res.bytes_left = remain_next;
                res.walk_done  = 1'b1;
            end
            phase_next  = PH_MAGIC;
            index_next  = '0;
            gather_next = '0;
            held_next   = '0;
            remain_next = '0;
            skip_next   = '0;
        end
    end

    assign res_valid = accept && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            index_reg  <= '0;
            gather_reg <= '0;
            held_reg   <= '0;
            remain_reg <= '0;
            skip_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            gather_reg <= gather_next;
            held_reg   <= held_next;
            remain_reg <= remain_next;
            skip_reg   <= skip_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rcw_out_buf.sv
// Result register with one skid entry for the RIFF chunk header walker.
// Depends on rcw_pkg.
`default_nettype none
module rcw_out_buf
    import rcw_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire rcw_result_t  push_data,
    output logic              full,
    output logic              out_valid,
    input  wire logic         out_stall,
    output rcw_result_t       out_data
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    rcw_result_t out_reg;
    rcw_result_t skid_reg;
    logic        pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rcw_checker.sv
// Port-level checks for the RIFF chunk header walker, bound to the top level.
// Depends on rcw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rcw_checker
    import rcw_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [7:0]  data_byte,
    input wire logic        end_of_file,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  event_res,
    input wire logic [31:0] tag,
    input wire logic [31:0] length,
    input wire logic [31:0] bytes_left,
    input wire logic        walk_done
);

    logic [31:0] type_left;
    logic        unused_in;
    logic        out_held;
    logic        trunc_seen;
    logic        trunc_ok;
    logic        not_riff_seen;
    logic        not_riff_ok;
    logic        header_seen;
    logic        header_ok;

    assign type_left     = (length > TYPE_BYTES) ? (length - TYPE_BYTES) : '0;
    assign unused_in     = in_valid ^ (^data_byte) ^ end_of_file;
    assign out_held      = out_valid && out_stall;
    assign trunc_seen    = out_valid && (event_res == EV_TRUNC);
    assign trunc_ok      = walk_done && (tag == '0) && (length == '0);
    assign not_riff_seen = out_valid && (event_res == EV_NOT_RIFF);
    assign not_riff_ok   = walk_done && (length == '0) && (bytes_left == '0);
    assign header_seen   = out_valid && (event_res == EV_HEADER);
    assign header_ok     = !walk_done && (bytes_left == type_left);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(tag) && $stable(bytes_left))
    `ASSERT_SAME(a_stall_full, clk, rst_n, in_stall || (unused_in && 1'b0), out_valid)
    `ASSERT_SAME(a_trunc, clk, rst_n, trunc_seen, trunc_ok)
    `ASSERT_SAME(a_not_riff, clk, rst_n, not_riff_seen, not_riff_ok)
    `ASSERT_SAME(a_header, clk, rst_n, header_seen, header_ok)

endmodule

bind riff_chunk_header_walker rcw_checker u_rcw_checker (.*);
`default_nettype wire
